// File: src/gmsp_pkg.sv
// shared constants, types and helpers for the grid path search block
package gmsp_pkg;

	localparam int GRID_SIDE = 5;
	localparam int CELL_BITS = 16;
	localparam int IN_BITS   = 16;
	localparam int OUT_BITS  = 21;
	localparam int NCELLS    = GRID_SIDE * GRID_SIDE;
	localparam int IDX_BITS  = $clog2(NCELLS);
	localparam int SP_BITS   = $clog2(NCELLS + 1);
	localparam int RC_BITS   = $clog2(GRID_SIDE);
	localparam int SUM_BITS  = CELL_BITS + $clog2(NCELLS);

	typedef logic [RC_BITS-1:0]         rc_t;
	typedef logic [IDX_BITS-1:0]        idx_t;
	typedef logic [CELL_BITS-1:0]       cell_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;

	typedef enum logic [2:0] {
		DIR_UP    = 3'd0,
		DIR_DOWN  = 3'd1,
		DIR_RIGHT = 3'd2,
		DIR_LEFT  = 3'd3,
		DIR_DONE  = 3'd4
	} dir_t;

	typedef struct packed {
		rc_t  row;
		rc_t  col;
		dir_t dir;
	} frame_t;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_SUB = 1'b1
	} alu_op_t;

	function automatic idx_t cell_index(input rc_t r, input rc_t c);
		cell_index = IDX_BITS'(int'(r) * GRID_SIDE + int'(c));
	endfunction

	function automatic sum_t sext_cell(input cell_t raw);
		sext_cell = SUM_BITS'($signed(raw));
	endfunction

endpackage

// File: src/gmsp_if.sv
// valid/ready channels for grid cell words and search result words
interface gmsp_cell_if;
	import gmsp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [IN_BITS-1:0] cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmsp_res_if;
	import gmsp_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] best_sum;
	logic                       path_found;

	modport source (output valid, output best_sum, output path_found, input ready);
	modport sink   (input valid, input best_sum, input path_found, output ready);
endinterface

// File: src/gmsp_ram.sv
// generic single write, single read ram with registered read data
module gmsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/gmsp_alu.sv
// shared adder and compare for running sum updates and best sum tracking
module gmsp_alu (
	input  gmsp_pkg::alu_op_t op,
	input  gmsp_pkg::sum_t    sum,
	input  gmsp_pkg::cell_t   cell_val,
	input  gmsp_pkg::sum_t    best,
	output gmsp_pkg::sum_t    res,
	output logic              less
);
	import gmsp_pkg::*;

	sum_t operand;

	always_comb begin
		operand = sext_cell(cell_val);
		unique case (op)
			OP_ADD: res = sum + operand;
			OP_SUB: res = sum - operand;
			default: res = sum;
		endcase
		less = res < best;
	end

endmodule

// File: src/grid_min_simple_path_search.sv
// top level: cell loading, depth-first search sequencer and result register
// loading takes cell words while valid; after the last cell the sequencer runs init and start,
// then step, visit and pop states until the stack empties; the result word is registered in done
// throughput: one grid per 25 cell words plus the search; input stalls during search
// reset: arst_n clears the sequencer, counters, path marks, sums and result valid;
// the grid ram and stack frames hold no reset and are written before they are read
module grid_min_simple_path_search (
	input logic          clk,
	input logic          arst_n,
	gmsp_cell_if.sink    cells,
	gmsp_res_if.source   results
);
	import gmsp_pkg::*;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_INIT  = 7'b0000010,
		ST_START = 7'b0000100,
		ST_STEP  = 7'b0001000,
		ST_POP   = 7'b0010000,
		ST_VISIT = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t                     state_q;
	idx_t                       load_cnt_q;
	logic [SP_BITS-1:0]         sp_q;
	frame_t                     stack_q [NCELLS];
	logic [NCELLS-1:0]          marks_q;
	sum_t                       sum_q;
	sum_t                       best_q;
	logic                       found_q;
	rc_t                        nrow_q;
	rc_t                        ncol_q;
	idx_t                       nidx_q;
	logic                       out_valid_q;
	logic signed [OUT_BITS-1:0] out_sum_q;
	logic                       out_found_q;

	logic    wr_en;
	cell_t   wr_data;
	idx_t    rd_addr;
	cell_t   rd_data;
	idx_t    top_idx;
	frame_t  top;
	logic    nb_valid;
	rc_t     nb_row;
	rc_t     nb_col;
	idx_t    nb_idx;
	logic    blocked;
	alu_op_t alu_op;
	sum_t    alu_res;
	logic    alu_less;
	logic    at_goal;
	logic    can_emit;
	logic    step_adv;
	logic    push_en;

	assign cells.ready        = (state_q == ST_LOAD);
	assign wr_en              = cells.valid && cells.ready;
	assign wr_data            = CELL_BITS'($unsigned(cells.cell_value));
	assign results.valid      = out_valid_q;
	assign results.best_sum   = out_sum_q;
	assign results.path_found = out_found_q;
	assign can_emit           = !out_valid_q || results.ready;

	assign top_idx = (sp_q == '0) ? '0 : IDX_BITS'(sp_q - SP_BITS'(1));
	assign top     = stack_q[top_idx];

	always_comb begin
		nb_valid = 1'b0;
		nb_row   = top.row;
		nb_col   = top.col;
		unique case (top.dir)
			DIR_UP: begin
				nb_valid = top.row != '0;
				nb_row   = top.row - rc_t'(1);
			end
			DIR_DOWN: begin
				nb_valid = top.row != rc_t'(GRID_SIDE - 1);
				nb_row   = top.row + rc_t'(1);
			end
			DIR_RIGHT: begin
				nb_valid = top.col != rc_t'(GRID_SIDE - 1);
				nb_col   = top.col + rc_t'(1);
			end
			DIR_LEFT: begin
				nb_valid = top.col != '0;
				nb_col   = top.col - rc_t'(1);
			end
			default: nb_valid = 1'b0;
		endcase
		nb_idx  = cell_index(nb_row, nb_col);
		blocked = !nb_valid || marks_q[nb_idx];
	end

	always_comb begin
		priority if (state_q == ST_INIT) begin
			rd_addr = '0;
		end else if (top.dir == DIR_DONE) begin
			rd_addr = cell_index(top.row, top.col);
		end else begin
			rd_addr = nb_idx;
		end
	end

	assign alu_op  = (state_q == ST_POP) ? OP_SUB : OP_ADD;
	assign at_goal = (nrow_q == rc_t'(GRID_SIDE - 1)) && (ncol_q == rc_t'(GRID_SIDE - 1));

	assign step_adv = (state_q == ST_STEP) && (sp_q != '0) && (top.dir != DIR_DONE);
	assign push_en  = (state_q == ST_VISIT) && (rd_data != '0) && !at_goal &&
		(sp_q != SP_BITS'(NCELLS));

	gmsp_ram #(
		.WIDTH (CELL_BITS),
		.DEPTH (NCELLS)
	) u_grid (
		.clk   (clk),
		.we    (wr_en),
		.waddr (load_cnt_q),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	gmsp_alu u_alu (
		.op       (alu_op),
		.sum      (sum_q),
		.cell_val (rd_data),
		.best     (best_q),
		.res      (alu_res),
		.less     (alu_less)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= '0;
			sp_q        <= '0;
			marks_q     <= '0;
			sum_q       <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (wr_en) begin
						if (load_cnt_q == idx_t'(NCELLS - 1)) begin
							load_cnt_q <= '0;
							state_q    <= ST_INIT;
						end else begin
							load_cnt_q <= load_cnt_q + idx_t'(1);
						end
					end
				end
				ST_INIT: begin
					state_q <= ST_START;
				end
				ST_START: begin
					sum_q      <= alu_res;
					best_q     <= '0;
					found_q    <= 1'b0;
					marks_q[0] <= 1'b1;
					sp_q       <= SP_BITS'(1);
					state_q    <= ST_STEP;
				end
				ST_STEP: begin
					if (sp_q == '0) begin
						state_q <= ST_DONE;
					end else if (top.dir == DIR_DONE) begin
						state_q <= ST_POP;
					end else if (!blocked) begin
						state_q <= ST_VISIT;
					end
				end
				ST_POP: begin
					sum_q <= alu_res;
					marks_q[cell_index(top.row, top.col)] <= 1'b0;
					sp_q    <= sp_q - SP_BITS'(1);
					state_q <= ST_STEP;
				end
				ST_VISIT: begin
					state_q <= ST_STEP;
					if (rd_data != '0) begin
						if (at_goal) begin
							if (!found_q || alu_less) begin
								best_q <= alu_res;
							end
							found_q <= 1'b1;
						end else if (sp_q != SP_BITS'(NCELLS)) begin
							marks_q[nidx_q] <= 1'b1;
							sum_q           <= alu_res;
							sp_q            <= sp_q + SP_BITS'(1);
						end
					end
				end
				ST_DONE: begin
					if (can_emit) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			stack_q[0] <= '{row: '0, col: '0, dir: DIR_UP};
		end
		if (step_adv) begin
			stack_q[top_idx].dir <= dir_t'(top.dir + 3'd1);
			if (!blocked) begin
				nrow_q <= nb_row;
				ncol_q <= nb_col;
				nidx_q <= nb_idx;
			end
		end
		if (push_en) begin
			stack_q[sp_q[IDX_BITS-1:0]] <= '{row: nrow_q, col: ncol_q, dir: DIR_UP};
		end
		if (state_q == ST_DONE && can_emit) begin
			out_sum_q   <= OUT_BITS'(best_q);
			out_found_q <= found_q;
		end
	end

	a_marks_match_depth: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(marks_q) == int'(sp_q))
		else $error("path marks disagree with stack depth");

	a_sp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_BITS'(NCELLS))
		else $error("stack pointer beyond depth");

	a_start_on_path: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q != '0) |-> marks_q[0])
		else $error("start cell left the path while search active");

	a_no_path_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.path_found) |-> (results.best_sum == '0))
		else $error("nonzero sum word without a path");

endmodule
